>>> rtl/core/flat_json_object_tokenizer_top_defines.svh
// Assertion macros shared by the tokenizer RTL.
`ifndef FLAT_JSON_OBJECT_TOKENIZER_TOP_DEFINES_SVH
`define FLAT_JSON_OBJECT_TOKENIZER_TOP_DEFINES_SVH

// Generic clocked assertion with explicit clock and active-low reset.
`define FJT_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Assertion on the block clock and reset.
`define FJT_ASSERT(lbl, prop, msg) \
  `FJT_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

>>> rtl/core/fjt_pkg.sv
// Shared types, constants and literal tables for the JSON object tokenizer.
`default_nettype none
package fjt_pkg;

  localparam int unsigned FjtQueueDepth = 4;

  localparam logic [15:0] MaxKeyReset   = 16'd511;
  localparam logic [15:0] MaxValueReset = 16'd4095;

  // Configuration register indexes
  localparam logic CfgMaxKey   = 1'b0;
  localparam logic CfgMaxValue = 1'b1;

  // Result kinds
  localparam logic [1:0] KindKey    = 2'd0;
  localparam logic [1:0] KindValue  = 2'd1;
  localparam logic [1:0] KindCommit = 2'd2;
  localparam logic [1:0] KindEnd    = 2'd3;

  // Literal kinds
  localparam logic [1:0] LitTrue  = 2'd0;
  localparam logic [1:0] LitFalse = 2'd1;
  localparam logic [1:0] LitNull  = 2'd2;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_byte;
  } fjt_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] out_kind;
    logic       run_last;
  } fjt_out_t;

  // One queued command: data bytes first, then commit, then document end.
  typedef struct packed {
    logic [2:0] data_cnt;   // 0..5 data items
    logic       lit;        // data bytes come from the literal table
    logic [1:0] lit_kind;
    logic [1:0] data_kind;  // key or value for a single byte
    logic [7:0] data_byte;
    logic       commit;
    logic       doc_end;
  } fjt_cmd_t;

  function automatic logic [2:0] lit_len(input logic [1:0] kind);
    case (kind)
      LitTrue:  lit_len = 3'd4;
      LitFalse: lit_len = 3'd5;
      LitNull:  lit_len = 3'd4;
      default:  lit_len = 3'd0;
    endcase
  endfunction

  function automatic logic [7:0] lit_char(input logic [1:0] kind, input logic [2:0] pos);
    logic [7:0] ch;
    ch = 8'd0;
    case (kind)
      LitTrue: begin
        case (pos)
          3'd0:    ch = "t";
          3'd1:    ch = "r";
          3'd2:    ch = "u";
          3'd3:    ch = "e";
          default: ch = 8'd0;
        endcase
      end
      LitFalse: begin
        case (pos)
          3'd0:    ch = "f";
          3'd1:    ch = "a";
          3'd2:    ch = "l";
          3'd3:    ch = "s";
          3'd4:    ch = "e";
          default: ch = 8'd0;
        endcase
      end
      LitNull: begin
        case (pos)
          3'd0:    ch = "n";
          3'd1:    ch = "u";
          3'd2:    ch = "l";
          3'd3:    ch = "l";
          default: ch = 8'd0;
        endcase
      end
      default: ch = 8'd0;
    endcase
    lit_char = ch;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/fjt_front.sv
// Front end: accepts bytes, runs the parse state machine, queues result commands.
`default_nettype none
module fjt_front
  import fjt_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire fjt_in_t     in_data_i,
  input  wire logic        q_full_i,
  output logic             q_push_o,
  output fjt_cmd_t         q_cmd_o
);

  typedef enum logic [3:0] {
    PhWait, PhObj, PhKey, PhKeyEsc, PhAfterKey, PhBeforeV,
    PhVStr, PhVEsc, PhLit, PhNum, PhIgnore
  } phase_e;

  phase_e      ph_q, ph_d, ph_mid;
  logic [1:0]  lk_q, lk_d;
  logic [2:0]  lp_q, lp_d, lp_inc;
  logic [15:0] kc_q, kc_d;
  logic [15:0] vc_q, vc_d;
  logic [15:0] max_key_q, max_val_q;
  logic [15:0] val_room;
  logic [7:0]  c;
  logic        accept;
  logic        lit_hit;
  fjt_cmd_t    cmd;

  function automatic logic is_ws(input logic [7:0] b);
    is_ws = (b == 8'd32) || (b >= 8'd9 && b <= 8'd13);
  endfunction

  function automatic logic is_num(input logic [7:0] b);
    is_num = (b >= "0" && b <= "9") || b == "." || b == "e" || b == "E" ||
             b == "+" || b == "-";
  endfunction

  function automatic logic [7:0] unesc(input logic [7:0] b);
    case (b)
      "n":     unesc = 8'd10;
      "t":     unesc = 8'd9;
      "r":     unesc = 8'd13;
      default: unesc = b;
    endcase
  endfunction

  function automatic logic is_value_ph(input phase_e p);
    is_value_ph = (p == PhBeforeV) || (p == PhVStr) || (p == PhVEsc) ||
                  (p == PhLit) || (p == PhNum);
  endfunction

  // Next phase for a byte seen where a key, comma or close may come.
  function automatic phase_e obj_next(input logic [7:0] b);
    if (is_ws(b) || b == ",") obj_next = PhObj;
    else if (b == "\"")       obj_next = PhKey;
    else                      obj_next = PhIgnore;
  endfunction

  assign c          = in_data_i.in_byte;
  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign lp_inc     = lp_q + 3'd1;
  assign val_room   = max_val_q - vc_q;
  assign lit_hit    = (lp_q < lit_len(lk_q)) && (c == lit_char(lk_q, lp_q));

  always_comb begin
    ph_mid = ph_q;
    lk_d   = lk_q;
    lp_d   = lp_q;
    kc_d   = kc_q;
    vc_d   = vc_q;
    cmd    = '0;

    if (c == 8'd0) begin
      cmd.commit = is_value_ph(ph_q);
      ph_mid     = PhIgnore;
    end else begin
      case (ph_q)
        PhWait: begin
          if (c == "{")       ph_mid = PhObj;
          else if (!is_ws(c)) ph_mid = PhIgnore;
        end
        PhObj: begin
          ph_mid = obj_next(c);
          if (c == "\"") kc_d = '0;
        end
        PhKey, PhKeyEsc: begin
          if (ph_q == PhKey && c == "\\") begin
            ph_mid = PhKeyEsc;
          end else if (ph_q == PhKey && c == "\"") begin
            ph_mid = PhAfterKey;
          end else begin
            ph_mid = PhKey;
            if (kc_q < max_key_q) begin
              cmd.data_cnt  = 3'd1;
              cmd.data_kind = KindKey;
              cmd.data_byte = (ph_q == PhKeyEsc) ? unesc(c) : c;
              kc_d          = kc_q + 16'd1;
            end
          end
        end
        PhAfterKey: begin
          if (c == ":") begin
            vc_d   = '0;
            ph_mid = PhBeforeV;
          end else if (!is_ws(c)) begin
            ph_mid = PhIgnore;
          end
        end
        PhBeforeV: begin
          if (is_ws(c)) begin
            ph_mid = PhBeforeV;
          end else if (c == "\"") begin
            ph_mid = PhVStr;
          end else if (c == "t" || c == "f" || c == "n") begin
            lk_d   = (c == "t") ? LitTrue : ((c == "f") ? LitFalse : LitNull);
            lp_d   = 3'd1;
            ph_mid = PhLit;
          end else if (is_num(c)) begin
            ph_mid = PhNum;
            if (vc_q < max_val_q) begin
              cmd.data_cnt  = 3'd1;
              cmd.data_kind = KindValue;
              cmd.data_byte = c;
              vc_d          = vc_q + 16'd1;
            end
          end else begin
            // bad value byte: empty value, then re-examined as object byte
            cmd.commit = 1'b1;
            ph_mid     = obj_next(c);
            if (c == "\"") kc_d = '0;
          end
        end
        PhVStr, PhVEsc: begin
          if (ph_q == PhVStr && c == "\\") begin
            ph_mid = PhVEsc;
          end else if (ph_q == PhVStr && c == "\"") begin
            cmd.commit = 1'b1;
            ph_mid     = PhObj;
          end else begin
            ph_mid = PhVStr;
            if (vc_q < max_val_q) begin
              cmd.data_cnt  = 3'd1;
              cmd.data_kind = KindValue;
              cmd.data_byte = (ph_q == PhVEsc) ? unesc(c) : c;
              vc_d          = vc_q + 16'd1;
            end
          end
        end
        PhLit: begin
          if (lit_hit) begin
            lp_d = lp_inc;
            if (lp_inc == lit_len(lk_q)) begin
              // full match: emit as many literal bytes as the value limit allows
              if (vc_q < max_val_q) begin
                if (val_room < {13'd0, lit_len(lk_q)}) cmd.data_cnt = val_room[2:0];
                else                                   cmd.data_cnt = lit_len(lk_q);
              end
              cmd.lit      = 1'b1;
              cmd.lit_kind = lk_q;
              cmd.commit   = 1'b1;
              vc_d         = vc_q + {13'd0, cmd.data_cnt};
              ph_mid       = PhObj;
            end
          end else begin
            cmd.commit = 1'b1;
            ph_mid     = PhIgnore;
          end
        end
        PhNum: begin
          if (is_num(c)) begin
            if (vc_q < max_val_q) begin
              cmd.data_cnt  = 3'd1;
              cmd.data_kind = KindValue;
              cmd.data_byte = c;
              vc_d          = vc_q + 16'd1;
            end
          end else begin
            cmd.commit = 1'b1;
            ph_mid     = obj_next(c);
            if (c == "\"") kc_d = '0;
          end
        end
        default: ph_mid = ph_q;
      endcase
    end

    ph_d = ph_mid;
    if (in_data_i.last_byte) begin
      cmd.commit  = cmd.commit | is_value_ph(ph_mid);
      cmd.doc_end = 1'b1;
      ph_d        = PhWait;
      lk_d        = '0;
      lp_d        = '0;
      kc_d        = '0;
      vc_d        = '0;
    end
  end

  assign q_cmd_o  = cmd;
  assign q_push_o = accept && ((cmd.data_cnt != 3'd0) || cmd.commit || cmd.doc_end);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q      <= PhWait;
      lk_q      <= '0;
      lp_q      <= '0;
      kc_q      <= '0;
      vc_q      <= '0;
      max_key_q <= MaxKeyReset;
      max_val_q <= MaxValueReset;
    end else begin
      if (accept) begin
        ph_q <= ph_d;
        lk_q <= lk_d;
        lp_q <= lp_d;
        kc_q <= kc_d;
        vc_q <= vc_d;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgMaxKey:   max_key_q <= cfg_wdata_i;
          CfgMaxValue: max_val_q <= cfg_wdata_i;
          default:     max_key_q <= max_key_q;
        endcase
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/fjt_queue.sv
// Command queue between the parser and the result sequencer.
`default_nettype none
`include "flat_json_object_tokenizer_top_defines.svh"
module fjt_queue
  import fjt_pkg::*;
#(
  parameter int unsigned Depth = FjtQueueDepth
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire fjt_cmd_t push_cmd_i,
  output logic          full_o,
  input  wire logic     pop_i,
  output logic          valid_o,
  output fjt_cmd_t      head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] Full    = CntW'(Depth);

  fjt_cmd_t        mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == Full);
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == LastPtr) ? '0 : wr_q + PtrW'(1);
      if (pop_i)  rd_q <= (rd_q == LastPtr) ? '0 : rd_q + PtrW'(1);
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + CntW'(1);
        2'b01:   cnt_q <= cnt_q - CntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  `FJT_ASSERT(a_cnt_bound, cnt_q <= Full, "queue count above depth")
  `FJT_ASSERT(a_no_pop_empty, pop_i |-> valid_o, "pop from empty queue")
  `FJT_ASSERT(a_no_push_full, push_i |-> !full_o, "push into full queue")

endmodule
`default_nettype wire

>>> rtl/core/fjt_back.sv
// Back end: expands queued commands into result transfers through an output register.
`default_nettype none
`include "flat_json_object_tokenizer_top_defines.svh"
module fjt_back
  import fjt_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     q_valid_i,
  input  wire fjt_cmd_t q_head_i,
  output logic          q_pop_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output fjt_out_t      out_data_o
);

  logic [2:0] idx_q;
  logic [3:0] total;
  logic       is_last;
  logic       load;
  logic       out_valid_q;
  fjt_out_t   out_q, item;

  assign total   = {1'b0, q_head_i.data_cnt} + {3'd0, q_head_i.commit} +
                   {3'd0, q_head_i.doc_end};
  assign is_last = ({1'b0, idx_q} + 4'd1) == total;
  assign load    = q_valid_i && (!out_valid_q || out_ready_i);
  assign q_pop_o = load && is_last;

  always_comb begin
    item          = '0;
    item.run_last = is_last;
    if (idx_q < q_head_i.data_cnt) begin
      item.out_byte = q_head_i.lit ? lit_char(q_head_i.lit_kind, idx_q) : q_head_i.data_byte;
      item.out_kind = q_head_i.lit ? KindValue : q_head_i.data_kind;
    end else if (idx_q == q_head_i.data_cnt && q_head_i.commit) begin
      item.out_kind = KindCommit;
    end else begin
      item.out_kind = KindEnd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) out_q <= item;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        idx_q       <= is_last ? '0 : idx_q + 3'd1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `FJT_ASSERT(a_idx_bound, idx_q <= 3'd6, "item index past longest burst")
  `FJT_ASSERT(a_idx_step, (load && !is_last) |=> (idx_q != 3'd0), "index did not advance")
  `FJT_ASSERT(a_end_last, (out_valid_q && out_q.out_kind == KindEnd) |-> out_q.run_last,
              "document end not final item of its byte")

endmodule
`default_nettype wire

>>> rtl/core/flat_json_object_tokenizer_top.sv
// Top level of the streaming flat JSON object tokenizer.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------------
//  in      | input     | in_valid_i / in_ready_o | in_data_i  (in_byte, last_byte)
//  out     | output    | out_valid_o/out_ready_i | out_data_o (out_byte, out_kind, run_last)
//  cfg     | input     | cfg_we_i (no wait)      | cfg_idx_i, cfg_wdata_i
//
// One input byte per cycle is taken while the command queue has room; the
// parser state machine updates in the cycle of the transfer.
// Each byte yields zero to seven results; the sequencer drives one result
// transfer per cycle while the receiver is ready, so a completed literal (up to
// seven results) holds the input back once the QueueDepth-entry queue fills.
// An input transfer reaches the output through the command queue and the output register.
// Reset (rst_ni low, asynchronous) clears parser, queue and output valid and
// loads the length limits with their defaults; no clearing pass is needed.
`default_nettype none
module flat_json_object_tokenizer_top
  import fjt_pkg::*;
#(
  parameter int unsigned QueueDepth = FjtQueueDepth
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire fjt_in_t     in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output fjt_out_t         out_data_o,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [15:0] cfg_wdata_i
);

  // front -> queue
  logic     q_push, q_full;
  fjt_cmd_t q_push_cmd;
  // queue -> back
  logic     q_valid, q_pop;
  fjt_cmd_t q_head;

  // Parser: classifies each byte, tracks key/value lengths, holds limits.
  fjt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_cmd_o     (q_push_cmd)
  );

  // Short command queue decouples input stalls from output stalls.
  fjt_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (q_push_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .head_o     (q_head)
  );

  // Sequencer: one result per cycle into the registered output stage, while the output is not stalled.
  fjt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire

>>> verif/testbench.sv
// Self-checking testbench for the flat JSON object tokenizer.
`timescale 1ns / 100ps

module testbench;
  import fjt_pkg::*;

  // Run-length guard, in clock cycles. The slowest correct run is a few
  // hundred bytes, each with up to seven results that each wait out the
  // longest receiver stall, plus the longest source gap before the byte.
  localparam int unsigned CycleLimit = 400000;
  // Cycles allowed after the last expected result before the block counts as idle.
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned MaxBurst = 7;
  localparam int unsigned PrintCap = 40;

  // Parser phases of the tokenizer, as the predictor tracks them.
  typedef enum logic [3:0] {
    PhWait, PhObj, PhKey, PhKeyEsc, PhAfterKey, PhBeforeV,
    PhVstr, PhVesc, PhLit, PhNum, PhIgnore
  } parse_phase_e;

  // DUT ports; every input is known from time zero.
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  fjt_in_t     in_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  fjt_out_t    out_data_o;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;

  // Predictor state: mirrors the parser and the two length limits.
  parse_phase_e tok_phase = PhWait;
  logic [1:0]   tok_lit_kind = LitTrue;
  logic [2:0]   tok_lit_pos = '0;
  logic [15:0]  key_len = '0;
  logic [15:0]  value_len = '0;
  logic [15:0]  key_limit = MaxKeyReset;
  logic [15:0]  value_limit = MaxValueReset;

  // Results of the byte being predicted, and the store of tokens still due.
  fjt_out_t token_burst [MaxBurst];
  int       burst_len;
  fjt_out_t expected_tokens [$];

  // Bytes of the document about to be streamed in.
  logic [7:0] doc_bytes [$];

  int unsigned cycle_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned stall_left = 0;
  bit          src_idle_on = 1'b1;
  bit          sink_stall_on = 1'b1;

  flat_json_object_tokenizer_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #10 clk_i = ~clk_i;

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  function automatic string literal_word(input logic [1:0] kind);
    case (kind)
      LitTrue:  return "true";
      LitFalse: return "false";
      LitNull:  return "null";
      default:  return "";
    endcase
  endfunction

  function automatic bit is_space(input logic [7:0] c);
    return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic bit is_number_char(input logic [7:0] c);
    return (c >= "0" && c <= "9") || c == "." || c == "e" || c == "E" ||
           c == "+" || c == "-";
  endfunction

  function automatic logic [7:0] decode_escape(input logic [7:0] c);
    if (c == "n") return 8'd10;
    if (c == "t") return 8'd9;
    if (c == "r") return 8'd13;
    return c;
  endfunction

  // A byte burst never exceeds seven tokens; anything past that is lost.
  function automatic void emit_token(input logic [7:0] b, input logic [1:0] kind);
    fjt_out_t tok;
    if (burst_len < MaxBurst) begin
      tok.out_byte = b;
      tok.out_kind = kind;
      tok.run_last = 1'b0;
      token_burst[burst_len] = tok;
      burst_len++;
    end
  endfunction

  function automatic void emit_key_byte(input logic [7:0] b);
    if (key_len < key_limit) begin
      emit_token(b, KindKey);
      key_len++;
    end
  endfunction

  function automatic void emit_value_byte(input logic [7:0] b);
    if (value_len < value_limit) begin
      emit_token(b, KindValue);
      value_len++;
    end
  endfunction

  // End of input: any value phase commits, key phases drop silently.
  function automatic void flush_value();
    case (tok_phase)
      PhBeforeV, PhVstr, PhVesc, PhLit, PhNum: emit_token(8'h00, KindCommit);
      default: ;
    endcase
  endfunction

  // Byte seen where a key, comma, close brace or whitespace may stand.
  function automatic void expect_key(input logic [7:0] c);
    if (is_space(c) || c == ",") return;
    if (c == "\"") begin
      key_len = '0;
      tok_phase = PhKey;
    end else begin
      // close brace or junk: ignore until the document's last byte
      tok_phase = PhIgnore;
    end
  endfunction

  function automatic void parse_byte(input logic [7:0] c);
    string w;
    int i;
    if (c == 8'h00) begin
      flush_value();
      tok_phase = PhIgnore;
      return;
    end
    case (tok_phase)
      PhWait: begin
        if (c == "{") tok_phase = PhObj;
        else if (!is_space(c)) tok_phase = PhIgnore;
      end
      PhObj: expect_key(c);
      PhKey: begin
        if (c == "\\") tok_phase = PhKeyEsc;
        else if (c == "\"") tok_phase = PhAfterKey;
        else emit_key_byte(c);
      end
      PhKeyEsc: begin
        emit_key_byte(decode_escape(c));
        tok_phase = PhKey;
      end
      PhAfterKey: begin
        if (c == ":") begin
          value_len = '0;
          tok_phase = PhBeforeV;
        end else if (!is_space(c)) begin
          tok_phase = PhIgnore;
        end
      end
      PhBeforeV: begin
        if (is_space(c)) begin
        end else if (c == "\"") begin
          tok_phase = PhVstr;
        end else if (c == "t" || c == "f" || c == "n") begin
          tok_lit_kind = (c == "t") ? LitTrue : ((c == "f") ? LitFalse : LitNull);
          tok_lit_pos = 3'd1;
          tok_phase = PhLit;
        end else if (is_number_char(c)) begin
          emit_value_byte(c);
          tok_phase = PhNum;
        end else begin
          // bad value byte: empty value, then the byte is looked at again
          emit_token(8'h00, KindCommit);
          tok_phase = PhObj;
          expect_key(c);
        end
      end
      PhVstr: begin
        if (c == "\\") begin
          tok_phase = PhVesc;
        end else if (c == "\"") begin
          emit_token(8'h00, KindCommit);
          tok_phase = PhObj;
        end else begin
          emit_value_byte(c);
        end
      end
      PhVesc: begin
        emit_value_byte(decode_escape(c));
        tok_phase = PhVstr;
      end
      PhLit: begin
        w = literal_word(tok_lit_kind);
        if (tok_lit_pos < w.len() && c == 8'(w[tok_lit_pos])) begin
          tok_lit_pos = tok_lit_pos + 3'd1;
          if (tok_lit_pos == w.len()) begin
            for (i = 0; i < w.len(); i++) emit_value_byte(8'(w[i]));
            emit_token(8'h00, KindCommit);
            tok_phase = PhObj;
          end
        end else begin
          emit_token(8'h00, KindCommit);
          tok_phase = PhIgnore;
        end
      end
      PhNum: begin
        if (is_number_char(c)) begin
          emit_value_byte(c);
        end else begin
          emit_token(8'h00, KindCommit);
          tok_phase = PhObj;
          expect_key(c);
        end
      end
      default: ;
    endcase
  endfunction

  // Works out every token one accepted byte causes and queues them.
  function automatic void tokenize_byte(input logic [7:0] c, input logic last);
    int i;
    burst_len = 0;
    parse_byte(c);
    if (last) begin
      flush_value();
      emit_token(8'h00, KindEnd);
      tok_phase = PhWait;
      tok_lit_kind = LitTrue;
      tok_lit_pos = '0;
      key_len = '0;
      value_len = '0;
    end
    if (burst_len > 0) token_burst[burst_len - 1].run_last = 1'b1;
    for (i = 0; i < burst_len; i++) expected_tokens.push_back(token_burst[i]);
  endfunction

  // ---------------------------------------------------------------------
  // Monitor, sink stalls and run guard
  // ---------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    if (mismatch_count < PrintCap) $display("[cycle %0d] mismatch: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  // Input transfers feed the predictor before output transfers are
  // checked; each result passes the command queue and the output register after its byte.
  always @(posedge clk_i) begin : token_monitor
    fjt_out_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) tokenize_byte(in_data_i.in_byte, in_data_i.last_byte);
      if (out_valid_o && out_ready_i) begin
        if (expected_tokens.size() == 0) begin
          report_mismatch($sformatf("unexpected token byte %02h kind %0d",
                                    out_data_o.out_byte, out_data_o.out_kind));
        end else begin
          want = expected_tokens.pop_front();
          if (out_data_o.out_byte !== want.out_byte)
            report_mismatch($sformatf("out_byte %02h, want %02h",
                                      out_data_o.out_byte, want.out_byte));
          if (out_data_o.out_kind !== want.out_kind)
            report_mismatch($sformatf("out_kind %0d, want %0d",
                                      out_data_o.out_kind, want.out_kind));
          if (out_data_o.run_last !== want.run_last)
            report_mismatch($sformatf("run_last %0b, want %0b",
                                      out_data_o.run_last, want.run_last));
        end
      end
    end
  end

  // Receiver back-pressure: random stall bursts.
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      out_ready_i <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (sink_stall_on && $urandom_range(0, 5) == 0) begin
      out_ready_i <= 1'b0;
      stall_left <= $urandom_range(0, 18);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  // One byte transfer. Valid may drop for a gap only before the byte is
  // offered; once offered it holds until the transfer.
  task automatic send_byte(input logic [7:0] b, input logic last);
    fjt_in_t item;
    int unsigned gap;
    gap = 0;
    if (src_idle_on && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 19);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item.in_byte = b;
    item.last_byte = last;
    in_valid_i <= 1'b1;
    in_data_i <= item;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Streams doc_bytes; the final byte carries the last flag if asked.
  task automatic send_doc(input bit mark_last);
    int i;
    for (i = 0; i < doc_bytes.size(); i++)
      send_byte(doc_bytes[i], mark_last && (i == doc_bytes.size() - 1));
  endtask

  task automatic send_text(input string s, input bit mark_last);
    int i;
    doc_bytes.delete();
    for (i = 0; i < s.len(); i++) doc_bytes.push_back(8'(s[i]));
    send_doc(mark_last);
  endtask

  // Holds the input off until every due token has come out, then lets the
  // pipeline settle for bytes that cause no token.
  task automatic wait_tokens_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_tokens.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Writes both limits back to back while the block is idle.
  task automatic set_limits(input logic [15:0] keys, input logic [15:0] values);
    wait_tokens_drained();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CfgMaxKey;
    cfg_wdata_i <= keys;
    @(posedge clk_i);
    cfg_idx_i <= CfgMaxValue;
    cfg_wdata_i <= values;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    key_limit = keys;
    value_limit = values;
  endtask

  function automatic logic [7:0] pick_char(input string set);
    return 8'(set[$urandom_range(0, set.len() - 1)]);
  endfunction

  // Any byte that may stand unescaped inside a string, biased to letters.
  function automatic logic [7:0] string_char();
    logic [7:0] c;
    if ($urandom_range(0, 1)) return 8'($urandom_range(97, 122));
    do c = 8'($urandom_range(1, 255)); while (c == "\"" || c == "\\");
    return c;
  endfunction

  task automatic push_space();
    repeat ($urandom_range(0, 2)) doc_bytes.push_back(pick_char(" \t\n\r\013\014"));
  endtask

  task automatic push_string_body(input int unsigned n);
    repeat (n) begin
      if ($urandom_range(0, 5) == 0) begin
        doc_bytes.push_back("\\");
        if ($urandom_range(0, 3) == 0) doc_bytes.push_back(8'($urandom_range(1, 255)));
        else doc_bytes.push_back(pick_char("ntrq\"\\/"));
      end else begin
        doc_bytes.push_back(string_char());
      end
    end
  endtask

  // Mostly well-formed documents with random content; a share of them is
  // broken by junk, bad values, cut literals, early zero bytes or a cut end.
  task automatic build_random_document();
    string w;
    int unsigned pairs;
    int unsigned cut;
    int i;
    doc_bytes.delete();
    if ($urandom_range(0, 9) == 0) doc_bytes.push_back(8'($urandom_range(1, 255)));
    push_space();
    doc_bytes.push_back("{");
    pairs = $urandom_range(0, 4);
    repeat (pairs) begin
      push_space();
      doc_bytes.push_back("\"");
      push_string_body($urandom_range(0, 5));
      doc_bytes.push_back("\"");
      push_space();
      doc_bytes.push_back(":");
      push_space();
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          doc_bytes.push_back("\"");
          push_string_body($urandom_range(0, 6));
          doc_bytes.push_back("\"");
        end
        3, 4, 5: begin
          w = literal_word(2'($urandom_range(0, 2)));
          for (i = 0; i < w.len(); i++) doc_bytes.push_back(8'(w[i]));
        end
        6, 7: repeat ($urandom_range(1, 6)) doc_bytes.push_back(pick_char("0123456789.eE+-"));
        8: begin
          // a byte that cannot start a value
          if ($urandom_range(0, 2) == 0) doc_bytes.push_back(8'($urandom_range(1, 255)));
          else doc_bytes.push_back(pick_char(",}x[#"));
        end
        default: begin
          // literal cut short by a stray byte
          w = literal_word(2'($urandom_range(0, 2)));
          cut = $urandom_range(1, w.len() - 1);
          for (i = 0; i < cut; i++) doc_bytes.push_back(8'(w[i]));
          doc_bytes.push_back(8'($urandom_range(1, 255)));
        end
      endcase
      if ($urandom_range(0, 1)) doc_bytes.push_back(",");
    end
    case ($urandom_range(0, 5))
      0, 1, 2: begin
        push_space();
        doc_bytes.push_back("}");
        push_space();
      end
      3: begin
        doc_bytes.push_back(8'h00);
        doc_bytes.push_back(8'($urandom_range(0, 255)));
      end
      4: ;
      default: doc_bytes.push_back(8'($urandom_range(0, 255)));
    endcase
    if ($urandom_range(0, 7) == 0)
      doc_bytes[$urandom_range(0, doc_bytes.size() - 1)] = 8'($urandom_range(0, 255));
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Whitespace before the brace, an empty object, ignored bytes after the
  // close, a junk byte before any brace, and a document of whitespace only.
  task automatic test_prelude_and_close();
    send_text(" \t\n{ , }\377", 1'b1);
    send_text("x{", 1'b1);
    send_text("\n", 1'b1);
  endtask

  // Key and value escapes: n, t, r decode, anything else passes through;
  // extreme byte values inside strings.
  task automatic test_string_escapes();
    send_text("{\"\377\\n\":\"\001\\t\\r\\q\\\"\\\\\"}", 1'b1);
  endtask

  // All three literals, an exponent number closed by the brace, optional
  // commas. The sender holds off mid-literal until every token is out.
  task automatic test_literals_and_numbers();
    send_text("{\"t\":true,\"f\":false \"n\":nu", 1'b0);
    wait_tokens_drained();
    send_text("ll,\"v\":-1.5E+3e}", 1'b1);
  endtask

  // Bad value bytes commit an empty value; a number ends on the next key's
  // quote; a literal that departs from its word commits then errors.
  task automatic test_value_faults();
    send_text("{\"a\":,\"b\":7}", 1'b1);
    send_text("{\"c\":}", 1'b1);
    send_text("{\"g\":12\"h\":3 }", 1'b1);
    send_text("{\"d\":fax\"e\":1}", 1'b1);
    send_text("{x\"k\":1}", 1'b1);
    send_text("{\"k\" x:1}", 1'b1);
  endtask

  // Documents cut in every key and value phase, by the last flag or a zero byte.
  task automatic test_end_of_input();
    send_text("{\"a\":\"xy", 1'b1);
    send_text("{\"a\":\"\\", 1'b1);
    send_text("{\"k\\", 1'b1);
    send_text("{\"a", 1'b1);
    send_text("{\"a\"", 1'b1);
    send_text("{\"a\":", 1'b1);
    send_text("{\"a\":nu", 1'b1);
    send_text("{\"a\":12", 1'b1);
    send_text("{\"a\":5", 1'b0);
    send_byte(8'h00, 1'b0);
    send_text("q", 1'b1);
    send_byte(8'h00, 1'b1);
  endtask

  // Truncation at small limits, then no truncation at the largest.
  task automatic test_length_limits();
    set_limits(16'd1, 16'd2);
    send_text("{\"abc\":\"defg\",\"h\":12345,\"i\":false}", 1'b1);
    set_limits(16'd2, 16'd1);
    send_text("{\"xyz\":true \"p\\n\":\"\\t\\t\"}", 1'b1);
    set_limits(16'hFFFF, 16'hFFFF);
    send_text("{\"long key\":\"long value\"}", 1'b1);
  endtask

  task automatic test_random_documents(input int unsigned byte_budget);
    int unsigned sent;
    sent = 0;
    while (sent < byte_budget) begin
      build_random_document();
      send_doc(1'b1);
      sent += doc_bytes.size();
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed part starts at the reset limits
    test_prelude_and_close();
    test_string_escapes();
    test_literals_and_numbers();
    test_value_faults();
    test_end_of_input();
    test_length_limits();

    // random part across several limit settings
    test_random_documents(10);
    set_limits(16'd1, 16'd1);
    test_random_documents(10);
    set_limits(16'($urandom_range(1, 6)), 16'($urandom_range(1, 6)));
    test_random_documents(10);

    // last stretch: no gaps, no stalls, back to the reset limits
    src_idle_on = 1'b0;
    sink_stall_on = 1'b0;
    set_limits(MaxKeyReset, MaxValueReset);
    test_random_documents(10);

    wait_tokens_drained();
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> flat_json_object_tokenizer_top.f
+incdir+rtl/core
rtl/core/fjt_pkg.sv
rtl/core/fjt_front.sv
rtl/core/fjt_queue.sv
rtl/core/fjt_back.sv
rtl/core/flat_json_object_tokenizer_top.sv
verif/testbench.sv
